// ===== rtl/core/dpst_pkg.sv =====
// Package for the dual-port serial transmitter: request and register codes,
// port count limits and reset constants. No dependencies.
package dpst_pkg;

  localparam int unsigned MAX_PORTS     = 2;
  localparam int unsigned DEF_NUM_PORTS = 2;

  localparam int unsigned BIT_TIME_W = 20;

  localparam logic [BIT_TIME_W-1:0] RESET_BIT_TIME = 20'd32;
  localparam logic [3:0]            BT_BASE_SHIFT  = 4'd5;
  localparam logic [3:0]            BYTE_BITS      = 4'd8;
  localparam int unsigned           TX_EN_BIT      = 5;

  typedef enum logic [1:0] {
    REQ_TICK  = 2'd0,
    REQ_WRITE = 2'd1,
    REQ_READ  = 2'd2
  } req_e;

  typedef enum logic [2:0] {
    REG_CLK_SEL = 3'd0,
    REG_RATE    = 3'd1,
    REG_CTRL    = 3'd2,
    REG_DATA    = 3'd3
  } reg_e;

endpackage

// ===== rtl/core/dual_port_serial_transmitter_top.sv =====
// Dual-port serial transmitter, top level.
// Depends on dpst_pkg (request codes, register codes, reset constants).
//
// Bus-driven transmitter with up to two ports. Each input word is a tick (one CPU
// cycle), a register write or a register read; address bit 3 picks the port,
// bits 2..0 the register (0 clock select, 1 rate, 2 control, 3 data). Data bytes
// go out LSB first, one bit per bit time, with a one-byte buffer behind the
// shifter. The block takes one word every cycle: a word is held in the input
// register, is applied to the port state in a single pass of logic, and its
// result word is registered in the output register when the word advances.
// Only a stalled output register holds the input side back. Reads return zero.
module dual_port_serial_transmitter_top
  import dpst_pkg::*;
#(
  parameter int unsigned NUM_PORTS = DEF_NUM_PORTS
) (
  input  logic       clk_i,
  input  logic       rst_ni,

  input  logic       in_valid_i,
  output logic       in_stall_o,
  input  logic [1:0] req_type_i,
  input  logic [3:0] addr_i,
  input  logic [7:0] wdata_i,

  output logic       out_valid_o,
  input  logic       out_stall_i,
  output logic [7:0] read_data_o,
  output logic [1:0] bit_strobe_o,
  output logic [1:0] bit_values_o,
  output logic [1:0] byte_done_o,
  output logic [7:0] byte_port0_o,
  output logic [7:0] byte_port1_o,
  output logic [1:0] dreq_raise_o,
  output logic [1:0] dreq_drop_o
);

  // input register
  logic       in_valid_q;
  logic [1:0] req_type_q;
  logic [3:0] addr_q;
  logic [7:0] wdata_q;

  logic       advance;
  logic       out_valid_q;

  assign advance    = in_valid_q && (!out_valid_q || !out_stall_i);
  assign in_stall_o = in_valid_q && out_valid_q && out_stall_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (!in_stall_o) begin
      in_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && !in_stall_o) begin
      req_type_q <= req_type_i;
      addr_q     <= addr_i;
      wdata_q    <= wdata_i;
    end
  end

  // per-port state
  logic [1:0]            cs_q     [NUM_PORTS];
  logic [1:0]            cs_d     [NUM_PORTS];
  logic [7:0]            rate_q   [NUM_PORTS];
  logic [7:0]            rate_d   [NUM_PORTS];
  logic [BIT_TIME_W-1:0] btime_q  [NUM_PORTS];
  logic [BIT_TIME_W-1:0] btime_d  [NUM_PORTS];
  logic [7:0]            ctrl_q   [NUM_PORTS];
  logic [7:0]            ctrl_d   [NUM_PORTS];
  logic                  bempty_q [NUM_PORTS];
  logic                  bempty_d [NUM_PORTS];
  logic [3:0]            brem_q   [NUM_PORTS];
  logic [3:0]            brem_d   [NUM_PORTS];
  logic [7:0]            shift_q  [NUM_PORTS];
  logic [7:0]            shift_d  [NUM_PORTS];
  logic [7:0]            hold_q   [NUM_PORTS];
  logic [7:0]            hold_d   [NUM_PORTS];
  logic [7:0]            asm_q    [NUM_PORTS];
  logic [7:0]            asm_d    [NUM_PORTS];
  logic [BIT_TIME_W-1:0] cnt_q    [NUM_PORTS];
  logic [BIT_TIME_W-1:0] cnt_d    [NUM_PORTS];

  // result of the word in the input register
  logic [MAX_PORTS-1:0] strobe_c, vals_c, done_c, raise_c, drop_c;
  logic [7:0]           bytes_c [MAX_PORTS];

  always_comb begin
    logic       b;
    logic       scan_ctrl;
    logic [8:0] rate_p1;
    logic [3:0] shamt;

    cs_d     = cs_q;
    rate_d   = rate_q;
    btime_d  = btime_q;
    ctrl_d   = ctrl_q;
    bempty_d = bempty_q;
    brem_d   = brem_q;
    shift_d  = shift_q;
    hold_d   = hold_q;
    asm_d    = asm_q;
    cnt_d    = cnt_q;

    strobe_c  = '0;
    vals_c    = '0;
    done_c    = '0;
    raise_c   = '0;
    drop_c    = '0;
    scan_ctrl = 1'b0;
    b         = 1'b0;
    rate_p1   = '0;
    shamt     = '0;
    for (int i = 0; i < MAX_PORTS; i++) begin
      bytes_c[i] = '0;
    end

    unique case (req_e'(req_type_q))
      REQ_TICK: begin
        for (int p = 0; p < NUM_PORTS; p++) begin
          if (brem_d[p] != 4'd0) begin
            if (cnt_d[p] > BIT_TIME_W'(1)) begin
              cnt_d[p] = cnt_d[p] - BIT_TIME_W'(1);
            end else begin
              b           = shift_d[p][0];
              shift_d[p]  = {1'b0, shift_d[p][7:1]};
              asm_d[p]    = {b, asm_d[p][7:1]};
              brem_d[p]   = brem_d[p] - 4'd1;
              strobe_c[p] = 1'b1;
              vals_c[p]   = b;
              if (brem_d[p] != 4'd0) begin
                cnt_d[p] = btime_q[p];
              end else begin
                done_c[p]  = 1'b1;
                bytes_c[p] = asm_d[p];
                if (!bempty_d[p]) begin
                  // buffered byte follows; the DMA scan sees ports in order
                  brem_d[p]   = BYTE_BITS;
                  shift_d[p]  = hold_d[p];
                  bempty_d[p] = 1'b1;
                  cnt_d[p]    = btime_q[p];
                  for (int q = 0; q < NUM_PORTS; q++) begin
                    if (bempty_d[q] && ctrl_d[q][TX_EN_BIT]) raise_c[q] = 1'b1;
                  end
                end
              end
            end
          end
        end
      end
      REQ_WRITE: begin
        for (int p = 0; p < NUM_PORTS; p++) begin
          if (addr_q[3] == 1'(p)) begin
            unique case (reg_e'(addr_q[2:0]))
              REG_CLK_SEL: cs_d[p] = wdata_q[1:0];
              REG_RATE: begin
                rate_d[p]  = wdata_q;
                rate_p1    = {1'b0, wdata_q} + 9'd1;
                shamt      = BT_BASE_SHIFT + {1'b0, cs_q[p], 1'b0};
                btime_d[p] = {11'b0, rate_p1} << shamt;
              end
              REG_CTRL: begin
                ctrl_d[p] = wdata_q;
                if (!wdata_q[TX_EN_BIT]) bempty_d[p] = 1'b1;
                scan_ctrl = 1'b1;
              end
              REG_DATA: begin
                if (!ctrl_q[p][TX_EN_BIT]) begin
                  hold_d[p] = wdata_q;
                end else if (brem_q[p] == 4'd0) begin
                  brem_d[p]   = BYTE_BITS;
                  shift_d[p]  = wdata_q;
                  bempty_d[p] = 1'b1;
                  cnt_d[p]    = btime_q[p];
                end else begin
                  hold_d[p]   = wdata_q;
                  bempty_d[p] = 1'b0;
                  drop_c[p]   = 1'b1;
                end
              end
              default: ;
            endcase
          end
        end
        if (scan_ctrl) begin
          for (int q = 0; q < NUM_PORTS; q++) begin
            if (bempty_d[q] && ctrl_d[q][TX_EN_BIT]) raise_c[q] = 1'b1;
          end
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int p = 0; p < NUM_PORTS; p++) begin
        cs_q[p]     <= '0;
        rate_q[p]   <= '0;
        btime_q[p]  <= RESET_BIT_TIME;
        ctrl_q[p]   <= '0;
        bempty_q[p] <= 1'b1;
        brem_q[p]   <= '0;
        shift_q[p]  <= '0;
        hold_q[p]   <= '0;
        asm_q[p]    <= '0;
        cnt_q[p]    <= '0;
      end
    end else if (advance) begin
      cs_q     <= cs_d;
      rate_q   <= rate_d;
      btime_q  <= btime_d;
      ctrl_q   <= ctrl_d;
      bempty_q <= bempty_d;
      brem_q   <= brem_d;
      shift_q  <= shift_d;
      hold_q   <= hold_d;
      asm_q    <= asm_d;
      cnt_q    <= cnt_d;
    end
  end

  // output register
  logic [1:0] strobe_q, vals_q, done_q, raise_q, drop_q;
  logic [7:0] byte0_q, byte1_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      strobe_q <= strobe_c;
      vals_q   <= vals_c;
      done_q   <= done_c;
      raise_q  <= raise_c;
      drop_q   <= drop_c;
      byte0_q  <= bytes_c[0];
      byte1_q  <= bytes_c[1];
    end
  end

  assign out_valid_o  = out_valid_q;
  assign read_data_o  = '0;
  assign bit_strobe_o = strobe_q;
  assign bit_values_o = vals_q;
  assign byte_done_o  = done_q;
  assign byte_port0_o = byte0_q;
  assign byte_port1_o = byte1_q;
  assign dreq_raise_o = raise_q;
  assign dreq_drop_o  = drop_q;

endmodule
